// File: hw/rtl/spi_cfs_pkg.sv
// spi_cfs_pkg: shared types, constants and the outgoing frame table
// for the seven-byte spi command frame slave; no dependencies
`default_nettype none

package spi_cfs_pkg;

    // frame geometry
    localparam int          FRAME_LEN  = 7;
    localparam logic [2:0]  POS_FIRST  = 3'd0;
    localparam logic [2:0]  POS_LAST   = 3'd6;

    // outgoing frame positions
    localparam logic [2:0]  POS_TX_F    = 3'd0;
    localparam logic [2:0]  POS_TX_P    = 3'd1;
    localparam logic [2:0]  POS_ADC_HI  = 3'd2;
    localparam logic [2:0]  POS_ADC_LO  = 3'd3;
    localparam logic [2:0]  POS_TX_K    = 3'd4;
    localparam logic [2:0]  POS_TX_4    = 3'd5;
    localparam logic [2:0]  POS_TX_Q    = 3'd6;

    // received frame positions
    localparam logic [2:0]  POS_MARK0   = 3'd0;
    localparam logic [2:0]  POS_MARK1   = 3'd1;
    localparam logic [2:0]  POS_DUTY    = 3'd2;
    localparam logic [2:0]  POS_PULSE   = 3'd3;
    localparam logic [2:0]  POS_LAMP    = 3'd4;
    localparam logic [2:0]  POS_MARK5   = 3'd5;
    localparam logic [2:0]  POS_MARK6   = 3'd6;

    // command limits
    localparam logic [7:0]  DUTY_MAX   = 8'd200;
    localparam logic [10:0] PULSE_BASE = 11'd1000;
    localparam logic [10:0] PULSE_MAX  = 11'd2000;

    // received frame markers
    localparam logic [7:0]  MARK0 = 8'h61; // 'a'
    localparam logic [7:0]  MARK1 = 8'h53; // 'S'
    localparam logic [7:0]  MARK5 = 8'h59; // 'Y'
    localparam logic [7:0]  MARK6 = 8'h6A; // 'j'

    // outgoing frame characters
    localparam logic [7:0]  TX_F = 8'h66; // 'f'
    localparam logic [7:0]  TX_P = 8'h50; // 'P'
    localparam logic [7:0]  TX_K = 8'h4B; // 'K'
    localparam logic [7:0]  TX_4 = 8'h34; // '4'
    localparam logic [7:0]  TX_Q = 8'h71; // 'q'

    // one result transaction
    typedef struct packed {
        logic [7:0]  tx_byte;
        logic [7:0]  motor_duty;
        logic [10:0] servo_pulse;
        logic        led_on;
        logic        frame_end;
        logic        frame_applied;
    } t_result;

    // outgoing byte at a frame position
    function automatic logic [7:0] outgoing_byte(input logic [2:0] pos,
                                                 input logic [9:0] adc);
        logic [7:0] b;
        case (pos)
            POS_TX_F:   b = TX_F;
            POS_TX_P:   b = TX_P;
            POS_ADC_HI: b = {6'd0, adc[9:8]};
            POS_ADC_LO: b = adc[7:0];
            POS_TX_K:   b = TX_K;
            POS_TX_4:   b = TX_4;
            POS_TX_Q:   b = TX_Q;
            default:    b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/spi_cfs_frame.sv
// spi_cfs_frame: byte position counter, received frame store, marker check
// and command registers; depends on spi_cfs_pkg
`default_nettype none

module spi_cfs_frame (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic [9:0]           i_adc_sample,
    output      spi_cfs_pkg::t_result o_result
);

    logic [2:0]  r_pos,   n_pos;
    logic [7:0]  r_frame  [spi_cfs_pkg::FRAME_LEN];
    logic [7:0]  n_frame  [spi_cfs_pkg::FRAME_LEN];
    logic [7:0]  r_duty,  n_duty;
    logic [10:0] r_pulse, n_pulse;
    logic        r_lamp,  n_lamp;
    logic        frame_end;
    logic        markers_ok;
    logic        apply;
    logic [10:0] pulse_raw;

    // frame contents after storing this byte
    always_comb begin
        for (int i = 0; i < spi_cfs_pkg::FRAME_LEN; i++) begin
            n_frame[i] = (r_pos == 3'(i)) ? i_rx_byte : r_frame[i];
        end
    end

    // frame end, marker check and clamped commands
    always_comb begin
        frame_end  = (r_pos >= spi_cfs_pkg::POS_LAST);
        markers_ok = (n_frame[spi_cfs_pkg::POS_MARK0] == spi_cfs_pkg::MARK0)
                  && (n_frame[spi_cfs_pkg::POS_MARK1] == spi_cfs_pkg::MARK1)
                  && (n_frame[spi_cfs_pkg::POS_MARK5] == spi_cfs_pkg::MARK5)
                  && (n_frame[spi_cfs_pkg::POS_MARK6] == spi_cfs_pkg::MARK6);
        apply      = frame_end && markers_ok;
        pulse_raw  = spi_cfs_pkg::PULSE_BASE
                   + {1'b0, n_frame[spi_cfs_pkg::POS_PULSE], 2'b00};
        n_pos      = frame_end ? spi_cfs_pkg::POS_FIRST : r_pos + 3'd1;
        n_duty     = r_duty;
        n_pulse    = r_pulse;
        n_lamp     = r_lamp;
        if (apply) begin
            n_duty  = (n_frame[spi_cfs_pkg::POS_DUTY] > spi_cfs_pkg::DUTY_MAX)
                    ? spi_cfs_pkg::DUTY_MAX : n_frame[spi_cfs_pkg::POS_DUTY];
            n_pulse = (pulse_raw > spi_cfs_pkg::PULSE_MAX)
                    ? spi_cfs_pkg::PULSE_MAX : pulse_raw;
            n_lamp  = (n_frame[spi_cfs_pkg::POS_LAMP] != 8'd0);
        end
    end

    // control and command registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= spi_cfs_pkg::POS_FIRST;
            r_duty  <= 8'd0;
            r_pulse <= 11'd0;
            r_lamp  <= 1'b0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_duty  <= n_duty;
            r_pulse <= n_pulse;
            r_lamp  <= n_lamp;
        end
    end

    // received frame store, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_frame <= n_frame;
        end
    end

    // result of this transaction
    always_comb begin
        o_result.tx_byte       = spi_cfs_pkg::outgoing_byte(r_pos, i_adc_sample);
        o_result.motor_duty    = n_duty;
        o_result.servo_pulse   = n_pulse;
        o_result.led_on        = n_lamp;
        o_result.frame_end     = frame_end;
        o_result.frame_applied = apply;
    end

endmodule

`default_nettype wire

// File: hw/rtl/spi_cfs_out.sv
// spi_cfs_out: result register with valid/ready handshake
// depends on spi_cfs_pkg
`default_nettype none

module spi_cfs_out (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire spi_cfs_pkg::t_result i_result,
    output      logic                 o_space,
    output      logic                 o_valid,
    input  wire logic                 i_ready,
    output      spi_cfs_pkg::t_result o_result
);

    logic                 r_valid;
    spi_cfs_pkg::t_result r_result;

    // room for a new result when empty or being drained
    assign o_space = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: hw/rtl/spi_command_frame_slave.sv
// spi_command_frame_slave: top level of the seven-byte spi command frame slave
// depends on spi_cfs_pkg, spi_cfs_frame, spi_cfs_out
//
// channel  direction  handshake                  payload
// rx       in         i_rx_valid / o_rx_ready    i_rx_byte, i_adc_sample
// tx       out        o_tx_valid / i_tx_ready    o_tx_byte, o_motor_duty, o_servo_pulse,
//                                                o_led_on, o_frame_end, o_frame_applied
//
// one byte per cycle while the output is not stalled; each result appears in the cycle after its byte is taken
// the single result register behind the frame logic holds each result until it is taken
// i_rst_n is synchronous: position and command registers clear, the frame store does not
// a stalled result holds the output; a new byte is still taken in the cycle it drains
`default_nettype none

module spi_command_frame_slave (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output      logic        o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [9:0]  i_adc_sample,
    output      logic        o_tx_valid,
    input  wire logic        i_tx_ready,
    output      logic [7:0]  o_tx_byte,
    output      logic [7:0]  o_motor_duty,
    output      logic [10:0] o_servo_pulse,
    output      logic        o_led_on,
    output      logic        o_frame_end,
    output      logic        o_frame_applied
);

    logic                 space;
    logic                 accept;
    spi_cfs_pkg::t_result next_result;
    spi_cfs_pkg::t_result out_result;

    // input transaction
    assign o_rx_ready = space;
    assign accept     = i_rx_valid && space;

    spi_cfs_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_rx_byte    (i_rx_byte),
        .i_adc_sample (i_adc_sample),
        .o_result     (next_result)
    );

    spi_cfs_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (next_result),
        .o_space  (space),
        .o_valid  (o_tx_valid),
        .i_ready  (i_tx_ready),
        .o_result (out_result)
    );

    // result fields
    assign o_tx_byte       = out_result.tx_byte;
    assign o_motor_duty    = out_result.motor_duty;
    assign o_servo_pulse   = out_result.servo_pulse;
    assign o_led_on        = out_result.led_on;
    assign o_frame_end     = out_result.frame_end;
    assign o_frame_applied = out_result.frame_applied;

endmodule

`default_nettype wire

// File: hw/rtl/spi_cfs_checker.sv
// spi_cfs_checker: port-level assertions for spi_command_frame_slave
// bound to the top level; no package dependency
`default_nettype none

module spi_cfs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_rx_ready,
    input wire logic        o_tx_valid,
    input wire logic        i_tx_ready,
    input wire logic [7:0]  o_tx_byte,
    input wire logic [7:0]  o_motor_duty,
    input wire logic [10:0] o_servo_pulse,
    input wire logic        o_frame_end,
    input wire logic        o_frame_applied
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tx_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && !i_tx_ready |=> o_tx_valid && $stable(o_tx_byte)
            && $stable(o_frame_end) && $stable(o_motor_duty))
        else $error("stalled result changed");

    // applied only on a frame end
    a_applied_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && o_frame_applied |-> o_frame_end)
        else $error("frame applied without frame end");

    // command ranges
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid |-> o_motor_duty <= 8'd200
            && (o_servo_pulse == 11'd0
                || (o_servo_pulse >= 11'd1000 && o_servo_pulse <= 11'd2000)))
        else $error("command out of range");

    // input ready whenever output is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_tx_valid |-> o_rx_ready)
        else $error("input stalled with empty output");

endmodule

bind spi_command_frame_slave spi_cfs_checker u_spi_cfs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_rx_ready      (o_rx_ready),
    .o_tx_valid      (o_tx_valid),
    .i_tx_ready      (i_tx_ready),
    .o_tx_byte       (o_tx_byte),
    .o_motor_duty    (o_motor_duty),
    .o_servo_pulse   (o_servo_pulse),
    .o_frame_end     (o_frame_end),
    .o_frame_applied (o_frame_applied)
);

`default_nettype wire
